/* design/mtbm_pkg.sv */
// ----------------------------------------------------------------------------
// mtbm_pkg: shared types and constants
// Request and result layouts, ring geometry and controller states for the
// multi-tier bucket store.
// ----------------------------------------------------------------------------
`default_nettype none

package mtbm_pkg;

  localparam int unsigned TIER0_SLOTS = 288;
  localparam int unsigned TIER1_SLOTS = 336;
  localparam int unsigned TIER2_SLOTS = 360;
  localparam int unsigned TIER3_SLOTS = 372;
  localparam int unsigned TOTAL_SLOTS = TIER0_SLOTS + TIER1_SLOTS + TIER2_SLOTS + TIER3_SLOTS;
  localparam int unsigned ADDR_W      = $clog2(TOTAL_SLOTS);
  localparam int unsigned SLOT_W      = 9;
  localparam int unsigned DIVN_W      = 48;
  localparam int unsigned DIVD_W      = 32;

  localparam logic [1:0] REQ_ADD  = 2'd0;
  localparam logic [1:0] REQ_SUM  = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  localparam logic [2:0] CFG_TIER0  = 3'd0;
  localparam logic [2:0] CFG_TIER1  = 3'd1;
  localparam logic [2:0] CFG_TIER2  = 3'd2;
  localparam logic [2:0] CFG_TIER3  = 3'd3;
  localparam logic [2:0] CFG_WINDOW = 3'd4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] epoch;
    logic [15:0] co2_ppm;
    logic [1:0]  tier;
    logic [8:0]  entry_index;
  } req_t;

  typedef struct packed {
    logic        valid_res;
    logic [31:0] bucket_start;
    logic [15:0] avg_ppm;
    logic [15:0] min_ppm;
    logic [15:0] max_ppm;
    logic [15:0] sample_count;
  } res_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_A_DL,
    ST_A_DW,
    ST_A_RD,
    ST_A_CMP,
    ST_A_MUL,
    ST_A_UDL,
    ST_A_UDW,
    ST_A_NEW,
    ST_S_INIT,
    ST_S_RD,
    ST_S_CHK,
    ST_S_ACC,
    ST_S_DL,
    ST_S_DW,
    ST_R_RD,
    ST_R_OUT
  } state_e;

  function automatic logic [SLOT_W-1:0] slots_of(input logic [1:0] t);
    logic [SLOT_W-1:0] s;
    unique case (t)
      2'd0:    s = SLOT_W'(TIER0_SLOTS);
      2'd1:    s = SLOT_W'(TIER1_SLOTS);
      2'd2:    s = SLOT_W'(TIER2_SLOTS);
      default: s = SLOT_W'(TIER3_SLOTS);
    endcase
    return s;
  endfunction

  function automatic logic [ADDR_W-1:0] base_of(input logic [1:0] t);
    logic [ADDR_W-1:0] b;
    unique case (t)
      2'd0:    b = '0;
      2'd1:    b = ADDR_W'(TIER0_SLOTS);
      2'd2:    b = ADDR_W'(TIER0_SLOTS + TIER1_SLOTS);
      default: b = ADDR_W'(TIER0_SLOTS + TIER1_SLOTS + TIER2_SLOTS);
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

/* design/multi_tier_bucket_min_max_avg.sv */
// ----------------------------------------------------------------------------
// multi_tier_bucket_min_max_avg: four-tier min/max/average bucket store
// Consolidates timestamped ppm samples into four circular rings of buckets
// and answers window summary and single-bucket read requests.
// ----------------------------------------------------------------------------
//  Channel   Ports                          Handshake
//  request   start, busy, req_i             taken when start && !busy
//  result    res_strobe_o, res_o            one-cycle strobe, no back-pressure
//  config    cfg_we_i, cfg_idx_i, cfg_data_i written when cfg_we_i is high
//
//  An add request visits the four tiers in turn, each through one bucket-width
//  division and, when the newest bucket is updated, a second division for the
//  running average. A summary request scans tier 0 bucket by bucket and ends
//  in one division when any bucket passes the window check. The add and summary
//  requests share one divider and the single memory port.
//  Reset clears the rings' head and fill counts; bucket memories are not
//  cleared. Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_tier_bucket_min_max_avg
  import mtbm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire req_t        req_i,
  output logic             res_strobe_o,
  output res_t             res_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);

  logic [31:0]            start_mem [TOTAL_SLOTS];
  logic [63:0]            stats_mem [TOTAL_SLOTS];

  logic [21:0]            width_q [4];
  logic [31:0]            win_q;
  logic [SLOT_W-1:0]      head_q [4];
  logic [SLOT_W-1:0]      fill_q [4];
  logic [SLOT_W-1:0]      head_d [4];
  logic [SLOT_W-1:0]      fill_d [4];

  state_e                 state_q, state_d;
  req_t                   req_q, req_d;
  logic [1:0]             tier_q, tier_d;
  logic [31:0]            astart_q, astart_d;
  logic [ADDR_W-1:0]      addr_q, addr_d;
  logic [31:0]            prod_q, prod_d;
  logic [SLOT_W-1:0]      ptr_q, ptr_d;
  logic [SLOT_W-1:0]      idx_q, idx_d;
  logic [41:0]            wsum_q, wsum_d;
  logic [24:0]            csum_q, csum_d;
  logic [15:0]            min_q, min_d;
  logic [15:0]            max_q, max_d;
  logic                   seen_q, seen_d;
  logic [31:0]            cutoff_q, cutoff_d;
  res_t                   res_q, res_d;
  logic                   strobe_q, strobe_d;

  logic                   mem_re, mem_we;
  logic [ADDR_W-1:0]      mem_addr;
  logic [31:0]            wr_start;
  logic [63:0]            wr_stats;
  logic [31:0]            rd_start_q;
  logic [63:0]            rd_stats_q;

  logic                   div_start, div_done;
  logic [DIVN_W-1:0]      div_n, div_quot;
  logic [DIVD_W-1:0]      div_d, div_rem;

  logic [SLOT_W-1:0]      slots, head, fill, newest, oldest;
  logic [SLOT_W:0]        pos_sum;
  logic [21:0]            width;
  logic [15:0]            rd_avg, rd_min, rd_max, rd_cnt;
  logic [15:0]            ppm;

  mtbm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (div_d),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign rd_avg = rd_stats_q[15:0];
  assign rd_min = rd_stats_q[31:16];
  assign rd_max = rd_stats_q[47:32];
  assign rd_cnt = rd_stats_q[63:48];
  assign ppm    = req_q.co2_ppm;
  assign busy   = (state_q != ST_IDLE);

  always_comb begin
    state_d   = state_q;
    req_d     = req_q;
    tier_d    = tier_q;
    astart_d  = astart_q;
    addr_d    = addr_q;
    prod_d    = prod_q;
    ptr_d     = ptr_q;
    idx_d     = idx_q;
    wsum_d    = wsum_q;
    csum_d    = csum_q;
    min_d     = min_q;
    max_d     = max_q;
    seen_d    = seen_q;
    cutoff_d  = cutoff_q;
    res_d     = res_q;
    strobe_d  = 1'b0;
    head_d    = head_q;
    fill_d    = fill_q;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = addr_q;
    wr_start  = astart_q;
    wr_stats  = '0;
    div_start = 1'b0;
    div_n     = '0;
    div_d     = '0;

    // The tier under work is always tier_q; for reads it holds the request's tier.
    slots   = slots_of(tier_q);
    head    = head_q[tier_q];
    fill    = fill_q[tier_q];
    width   = (width_q[tier_q] == '0) ? 22'd1 : width_q[tier_q];
    newest  = (head == '0) ? slots - 1'b1 : head - 1'b1;
    oldest  = (fill < slots) ? '0 : head;
    pos_sum = {1'b0, oldest} + {1'b0, req_q.entry_index};
    if (pos_sum >= {1'b0, slots}) begin
      pos_sum = pos_sum - {1'b0, slots};
    end
    prod_d  = {16'd0, rd_avg} * {16'd0, rd_cnt};

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          req_d = req_i;
          tier_d = 2'd0;
          priority if (req_i.req_type == REQ_ADD) begin
            state_d = (req_i.epoch == '0) ? ST_IDLE : ST_A_DL;
          end else if (req_i.req_type == REQ_SUM) begin
            state_d = ST_S_INIT;
          end else if (req_i.req_type == REQ_READ) begin
            tier_d  = req_i.tier;
            state_d = ST_R_RD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_A_DL: begin
        div_start = 1'b1;
        div_n     = DIVN_W'(req_q.epoch);
        div_d     = DIVD_W'(width);
        state_d   = ST_A_DW;
      end
      ST_A_DW: begin
        if (div_done) begin
          astart_d = req_q.epoch - div_rem;
          state_d  = (fill == '0) ? ST_A_NEW : ST_A_RD;
        end
      end
      ST_A_RD: begin
        mem_addr = base_of(tier_q) + ADDR_W'(newest);
        mem_re   = 1'b1;
        addr_d   = mem_addr;
        state_d  = ST_A_CMP;
      end
      ST_A_CMP: begin
        state_d = (rd_start_q == astart_q) ? ST_A_MUL : ST_A_NEW;
      end
      ST_A_MUL: begin
        state_d = ST_A_UDL;
      end
      ST_A_UDL: begin
        div_start = 1'b1;
        div_n     = DIVN_W'(prod_q) + DIVN_W'(ppm);
        div_d     = DIVD_W'(rd_cnt) + 1'b1;
        state_d   = ST_A_UDW;
      end
      ST_A_UDW: begin
        if (div_done) begin
          mem_we   = 1'b1;
          mem_addr = addr_q;
          wr_start = rd_start_q;
          wr_stats = {(rd_cnt == 16'hFFFF) ? rd_cnt : rd_cnt + 1'b1,
                      (ppm > rd_max) ? ppm : rd_max,
                      (ppm < rd_min) ? ppm : rd_min,
                      div_quot[15:0]};
          tier_d   = tier_q + 1'b1;
          state_d  = (tier_q == 2'd3) ? ST_IDLE : ST_A_DL;
        end
      end
      ST_A_NEW: begin
        mem_we         = 1'b1;
        mem_addr       = base_of(tier_q) + ADDR_W'(head);
        wr_start       = astart_q;
        wr_stats       = {16'd1, ppm, ppm, ppm};
        head_d[tier_q] = (head == slots - 1'b1) ? '0 : head + 1'b1;
        if (fill < slots) begin
          fill_d[tier_q] = fill + 1'b1;
        end
        tier_d  = tier_q + 1'b1;
        state_d = (tier_q == 2'd3) ? ST_IDLE : ST_A_DL;
      end
      ST_S_INIT: begin
        cutoff_d = (req_q.epoch > win_q) ? req_q.epoch - win_q : '0;
        ptr_d    = oldest;
        idx_d    = '0;
        wsum_d   = '0;
        csum_d   = '0;
        min_d    = '0;
        max_d    = '0;
        seen_d   = 1'b0;
        if (req_q.epoch == '0) begin
          res_d    = '0;
          strobe_d = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          state_d = ST_S_RD;
        end
      end
      ST_S_RD: begin
        if (idx_q >= fill) begin
          if (seen_q) begin
            state_d = ST_S_DL;
          end else begin
            res_d    = '0;
            strobe_d = 1'b1;
            state_d  = ST_IDLE;
          end
        end else begin
          mem_addr = ADDR_W'(ptr_q);
          mem_re   = 1'b1;
          state_d  = ST_S_CHK;
        end
      end
      ST_S_CHK: begin
        if (rd_start_q < cutoff_q || rd_cnt == '0) begin
          ptr_d   = (ptr_q == slots - 1'b1) ? '0 : ptr_q + 1'b1;
          idx_d   = idx_q + 1'b1;
          state_d = ST_S_RD;
        end else begin
          state_d = ST_S_ACC;
        end
      end
      ST_S_ACC: begin
        wsum_d  = wsum_q + 42'(prod_q);
        csum_d  = csum_q + 25'(rd_cnt);
        if (!seen_q || rd_min < min_q) begin
          min_d = rd_min;
        end
        if (!seen_q || rd_max > max_q) begin
          max_d = rd_max;
        end
        seen_d  = 1'b1;
        ptr_d   = (ptr_q == slots - 1'b1) ? '0 : ptr_q + 1'b1;
        idx_d   = idx_q + 1'b1;
        state_d = ST_S_RD;
      end
      ST_S_DL: begin
        div_start = 1'b1;
        div_n     = DIVN_W'(wsum_q);
        div_d     = DIVD_W'(csum_q);
        state_d   = ST_S_DW;
      end
      ST_S_DW: begin
        if (div_done) begin
          res_d           = '0;
          res_d.valid_res = 1'b1;
          res_d.avg_ppm   = div_quot[15:0];
          res_d.min_ppm   = min_q;
          res_d.max_ppm   = max_q;
          strobe_d        = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_R_RD: begin
        if (req_q.entry_index >= fill) begin
          res_d    = '0;
          strobe_d = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          mem_addr = base_of(tier_q) + ADDR_W'(pos_sum);
          mem_re   = 1'b1;
          state_d  = ST_R_OUT;
        end
      end
      ST_R_OUT: begin
        res_d.valid_res    = 1'b1;
        res_d.bucket_start = rd_start_q;
        res_d.avg_ppm      = rd_avg;
        res_d.min_ppm      = rd_min;
        res_d.max_ppm      = rd_max;
        res_d.sample_count = rd_cnt;
        strobe_d           = 1'b1;
        state_d            = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      strobe_q   <= 1'b0;
      width_q[0] <= 22'd300;
      width_q[1] <= 22'd1800;
      width_q[2] <= 22'd7200;
      width_q[3] <= 22'd43200;
      win_q      <= 32'd86400;
      for (int i = 0; i < 4; i++) begin
        head_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
      head_q   <= head_d;
      fill_q   <= fill_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TIER0:  width_q[0] <= cfg_data_i[21:0];
          CFG_TIER1:  width_q[1] <= cfg_data_i[21:0];
          CFG_TIER2:  width_q[2] <= cfg_data_i[21:0];
          CFG_TIER3:  width_q[3] <= cfg_data_i[21:0];
          CFG_WINDOW: win_q      <= cfg_data_i;
          default:    ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    tier_q   <= tier_d;
    astart_q <= astart_d;
    addr_q   <= addr_d;
    prod_q   <= prod_d;
    ptr_q    <= ptr_d;
    idx_q    <= idx_d;
    wsum_q   <= wsum_d;
    csum_q   <= csum_d;
    min_q    <= min_d;
    max_q    <= max_d;
    seen_q   <= seen_d;
    cutoff_q <= cutoff_d;
    res_q    <= res_d;
  end

  // Single-port bucket memories with registered read data.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      start_mem[mem_addr] <= wr_start;
      stats_mem[mem_addr] <= wr_stats;
    end
    if (mem_re) begin
      rd_start_q <= start_mem[mem_addr];
      rd_stats_q <= stats_mem[mem_addr];
    end
  end

  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

endmodule

`default_nettype wire

/* design/mtbm_div.sv */
// ----------------------------------------------------------------------------
// mtbm_div: shared restoring divider
// Produces one quotient bit per cycle; done pulses when quotient and
// remainder are ready.
// ----------------------------------------------------------------------------
`default_nettype none

module mtbm_div
  import mtbm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DIVN_W-1:0] dividend_i,
  input  wire logic [DIVD_W-1:0] divisor_i,
  output logic                   done_o,
  output logic [DIVN_W-1:0]      quot_o,
  output logic [DIVD_W-1:0]      rem_o
);

  localparam int unsigned CNT_W = $clog2(DIVN_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIVN_W-1:0] quo_q, quo_d;
  logic [DIVD_W-1:0] rem_q, rem_d;
  logic [DIVD_W-1:0] dvs_q, dvs_d;
  logic [DIVD_W:0]   shifted;
  logic [DIVD_W:0]   diff;

  always_comb begin
    shifted = {rem_q, quo_q[DIVN_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[DIVD_W]) begin
        rem_d = diff[DIVD_W-1:0];
        quo_d = {quo_q[DIVN_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[DIVD_W-1:0];
        quo_d = {quo_q[DIVN_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DIVN_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire
